[hdl/jfsc_pkg.sv]
// ----------------------------------------------------------------------------
// jfsc_pkg
// Shared types, codes and the CRC-32 byte step for the journal frame checker.
// ----------------------------------------------------------------------------
package jfsc_pkg;

	localparam int OFFSET_BITS_DEF = 32;
	localparam int HEADER_BYTES    = 32;
	localparam int POS_BITS        = 25;
	localparam int ADDR_BITS       = 4;

	localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
	// magic bytes at header offsets 0..3, byte 0 in the low lane
	localparam logic [31:0] FRAME_MAGIC = 32'h524A_5748;

	localparam logic [1:0] KIND_DATA    = 2'd0;
	localparam logic [1:0] KIND_END     = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;

	localparam logic [3:0] ST_OK        = 4'd0;
	localparam logic [3:0] ST_CLEAN_END = 4'd1;
	localparam logic [3:0] ST_MAGIC     = 4'd2;
	localparam logic [3:0] ST_VERSION   = 4'd3;
	localparam logic [3:0] ST_FIELDS    = 4'd4;
	localparam logic [3:0] ST_TOO_LARGE = 4'd5;
	localparam logic [3:0] ST_TRUNC_HDR = 4'd6;
	localparam logic [3:0] ST_TRUNC_PAY = 4'd7;
	localparam logic [3:0] ST_CRC       = 4'd8;
	localparam logic [3:0] ST_SEQ_GAP   = 4'd9;

	localparam logic [1:0] REG_SCHEMA_VERSION = 2'd0;
	localparam logic [1:0] REG_MAX_PAYLOAD    = 2'd1;
	localparam logic [1:0] REG_TYPE_FIRST     = 2'd2;
	localparam logic [1:0] REG_TYPE_LAST      = 2'd3;

	localparam logic [7:0]  SCHEMA_VERSION_RST = 8'd1;
	localparam logic [23:0] MAX_PAYLOAD_RST    = 24'd65536;
	localparam logic [15:0] TYPE_FIRST_RST     = 16'd1;
	localparam logic [15:0] TYPE_LAST_RST      = 16'd8;

	// fault flag bits
	localparam int FLT_MAGIC   = 0;
	localparam int FLT_VERSION = 1;
	localparam int FLT_FIELDS  = 2;

	typedef struct packed {
		logic [7:0]  schema_version;
		logic [23:0] max_payload;
		logic [15:0] type_first;
		logic [15:0] type_last;
	} cfg_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [15:0] record_type;
		logic [63:0] record_sequence;
		logic [31:0] payload_start;
		logic [23:0] payload_length;
		logic [31:0] error_offset;
	} result_t;

	// reflected CRC-32, one byte
	function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

[hdl/journal_frame_stream_checker_unit.sv]
// ----------------------------------------------------------------------------
// journal_frame_stream_checker_unit
// Byte-serial validator for CRC-32 framed journal records.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | sink      | in_valid / in_ready   | kind, data_byte
//  out     | source    | out_valid / out_ready | status, record_type, record_sequence,
//          |           |                       | payload_start, payload_length, error_offset
//  cfg     | APB slave | psel/penable/pready   | paddr, pwdata, prdata
//
// One byte per cycle while the result register is not stalled. A byte is
// registered in the input stage on accept; when it advances it updates the
// frame state and loads its verdict (if any) into the result register at the
// same edge.
// The CRC byte step and the 64-bit sequence compare set the cycle path.
// Reset returns all frame state at once; no clearing pass.
// A stalled result register holds the input stage, and in_ready drops then.
module journal_frame_stream_checker_unit #(
	parameter int OFFSET_BITS = jfsc_pkg::OFFSET_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     kind,
	input  logic [7:0]                     data_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [3:0]                     status,
	output logic [15:0]                    record_type,
	output logic [63:0]                    record_sequence,
	output logic [31:0]                    payload_start,
	output logic [23:0]                    payload_length,
	output logic [31:0]                    error_offset,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [jfsc_pkg::ADDR_BITS-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	localparam int PB = jfsc_pkg::POS_BITS;

	jfsc_pkg::cfg_t cfg;

	jfsc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input stage
	logic       valid_s1;
	logic [1:0] kind_s1;
	logic [7:0] byte_s1;
	logic       adv;

	// result register
	logic              out_valid_q;
	jfsc_pkg::result_t out_q;

	// frame state
	logic [OFFSET_BITS-1:0] stream_offset_q, stream_offset_n;
	logic [OFFSET_BITS-1:0] frame_start_q, frame_start_n;
	logic [PB-1:0]          frame_pos_q, frame_pos_n;
	logic [31:0]            crc_q, crc_n;
	logic [31:0]            stored_crc_q, stored_crc_n;
	logic [15:0]            hdr_type_q, hdr_type_n;
	logic [31:0]            hdr_len_q, hdr_len_n;
	logic [63:0]            hdr_seq_q, hdr_seq_n;
	logic [63:0]            exp_seq_q, exp_seq_n;
	logic [2:0]             fault_q, fault_n;
	logic                   halted_q, halted_n;

	logic              res_valid;
	jfsc_pkg::result_t res;

	function automatic logic [31:0] to_out32(logic [OFFSET_BITS-1:0] v);
		logic [OFFSET_BITS+31:0] e;
		e = {32'd0, v};
		return e[31:0];
	endfunction

	function automatic logic [7:0] FRAME_MAGIC_BYTE(logic [1:0] i);
		return jfsc_pkg::FRAME_MAGIC[8*i +: 8];
	endfunction

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1 <= kind;
			byte_s1 <= data_byte;
		end
	end

	always_comb begin
		logic [4:0]  p;
		logic        in_hdr;
		logic [7:0]  b;
		logic [PB:0] pos_inc;
		logic [32:0] frame_end;
		logic        finish;

		stream_offset_n = stream_offset_q;
		frame_start_n   = frame_start_q;
		frame_pos_n     = frame_pos_q;
		crc_n           = crc_q;
		stored_crc_n    = stored_crc_q;
		hdr_type_n      = hdr_type_q;
		hdr_len_n       = hdr_len_q;
		hdr_seq_n       = hdr_seq_q;
		exp_seq_n       = exp_seq_q;
		fault_n         = fault_q;
		halted_n        = halted_q;
		res_valid       = 1'b0;
		res             = '0;
		finish          = 1'b0;

		p         = frame_pos_q[4:0];
		in_hdr    = (frame_pos_q[PB-1:5] == '0);
		b         = byte_s1;
		pos_inc   = {1'b0, frame_pos_q} + {{PB{1'b0}}, 1'b1};
		frame_end = 33'(jfsc_pkg::HEADER_BYTES) + {1'b0, hdr_len_q};

		case (kind_s1)
			jfsc_pkg::KIND_RESTART: begin
				stream_offset_n = '0;
				frame_start_n   = '0;
				frame_pos_n     = '0;
				crc_n           = '1;
				stored_crc_n    = '0;
				hdr_type_n      = '0;
				hdr_len_n       = '0;
				hdr_seq_n       = '0;
				exp_seq_n       = 64'd1;
				fault_n         = '0;
				halted_n        = 1'b0;
			end
			jfsc_pkg::KIND_END: begin
				if (!halted_q) begin
					res_valid = 1'b1;
					if (frame_pos_q == '0) begin
						res.status = jfsc_pkg::ST_CLEAN_END;
					end else begin
						res.status       = in_hdr ? jfsc_pkg::ST_TRUNC_HDR
						                          : jfsc_pkg::ST_TRUNC_PAY;
						res.error_offset = to_out32(stream_offset_q);
						halted_n         = 1'b1;
					end
				end
			end
			jfsc_pkg::KIND_DATA: begin
				if (!halted_q) begin
					if (in_hdr) begin
						case (p) inside
							[5'd0:5'd3]: begin
								if (b != FRAME_MAGIC_BYTE(p[1:0]))
									fault_n[jfsc_pkg::FLT_MAGIC] = 1'b1;
							end
							5'd4: begin
								if (b != cfg.schema_version)
									fault_n[jfsc_pkg::FLT_VERSION] = 1'b1;
							end
							5'd5: begin
								if (b != 8'd0) fault_n[jfsc_pkg::FLT_VERSION] = 1'b1;
							end
							5'd6:          hdr_type_n[7:0]  = b;
							5'd7:          hdr_type_n[15:8] = b;
							[5'd12:5'd15]: hdr_len_n[8*p[1:0] +: 8]    = b;
							[5'd16:5'd23]: hdr_seq_n[8*p[2:0] +: 8]    = b;
							[5'd24:5'd27]: stored_crc_n[8*p[1:0] +: 8] = b;
							default: begin
								// flags word and reserved word must be zero
								if (b != 8'd0) fault_n[jfsc_pkg::FLT_FIELDS] = 1'b1;
							end
						endcase
						// CRC field counts as zero bytes
						crc_n = jfsc_pkg::crc32_byte(crc_q,
							(p[4:3] == 2'b11 && !p[2]) ? 8'd0 : b);
					end else begin
						crc_n = jfsc_pkg::crc32_byte(crc_q, b);
					end
					stream_offset_n = stream_offset_q + OFFSET_BITS'(1);
					frame_pos_n     = pos_inc[PB-1:0];

					if (pos_inc == (PB+1)'(jfsc_pkg::HEADER_BYTES)) begin
						if (fault_n[jfsc_pkg::FLT_MAGIC]) begin
							res_valid        = 1'b1;
							res.status       = jfsc_pkg::ST_MAGIC;
							res.error_offset = to_out32(frame_start_q);
							halted_n         = 1'b1;
						end else if (fault_n[jfsc_pkg::FLT_VERSION]) begin
							res_valid        = 1'b1;
							res.status       = jfsc_pkg::ST_VERSION;
							res.error_offset = to_out32(frame_start_q + OFFSET_BITS'(4));
							halted_n         = 1'b1;
						end else if (fault_n[jfsc_pkg::FLT_FIELDS] ||
						             hdr_type_n < cfg.type_first ||
						             hdr_type_n > cfg.type_last ||
						             hdr_seq_n == 64'd0) begin
							res_valid        = 1'b1;
							res.status       = jfsc_pkg::ST_FIELDS;
							res.error_offset = to_out32(frame_start_q + OFFSET_BITS'(6));
							halted_n         = 1'b1;
						end else if (hdr_len_n > {8'd0, cfg.max_payload}) begin
							res_valid        = 1'b1;
							res.status       = jfsc_pkg::ST_TOO_LARGE;
							res.error_offset = to_out32(frame_start_q + OFFSET_BITS'(12));
							halted_n         = 1'b1;
						end else if (hdr_len_n == 32'd0) begin
							finish = 1'b1;
						end
					end else if (!in_hdr && {{(32-PB){1'b0}}, pos_inc} == frame_end) begin
						finish = 1'b1;
					end

					if (finish) begin
						res_valid = 1'b1;
						if ((crc_n ^ 32'hFFFF_FFFF) != stored_crc_n) begin
							res.status       = jfsc_pkg::ST_CRC;
							res.error_offset = to_out32(frame_start_q + OFFSET_BITS'(24));
							halted_n         = 1'b1;
						end else if (exp_seq_q == 64'd0 || hdr_seq_n != exp_seq_q) begin
							res.status       = jfsc_pkg::ST_SEQ_GAP;
							res.error_offset = to_out32(frame_start_q + OFFSET_BITS'(16));
							halted_n         = 1'b1;
						end else begin
							// all-ones sequence wraps to zero: every later frame fails
							exp_seq_n           = hdr_seq_n + 64'd1;
							res.status          = jfsc_pkg::ST_OK;
							res.record_type     = hdr_type_n;
							res.record_sequence = hdr_seq_n;
							res.payload_start   = to_out32(frame_start_q +
								OFFSET_BITS'(jfsc_pkg::HEADER_BYTES));
							res.payload_length  = hdr_len_n[23:0];
							// open the next frame
							frame_start_n = stream_offset_n;
							frame_pos_n   = '0;
							crc_n         = '1;
							stored_crc_n  = '0;
							hdr_type_n    = '0;
							hdr_len_n     = '0;
							hdr_seq_n     = '0;
							fault_n       = '0;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_offset_q <= '0;
			frame_start_q   <= '0;
			frame_pos_q     <= '0;
			crc_q           <= '1;
			stored_crc_q    <= '0;
			hdr_type_q      <= '0;
			hdr_len_q       <= '0;
			hdr_seq_q       <= '0;
			exp_seq_q       <= 64'd1;
			fault_q         <= '0;
			halted_q        <= 1'b0;
		end else if (adv) begin
			stream_offset_q <= stream_offset_n;
			frame_start_q   <= frame_start_n;
			frame_pos_q     <= frame_pos_n;
			crc_q           <= crc_n;
			stored_crc_q    <= stored_crc_n;
			hdr_type_q      <= hdr_type_n;
			hdr_len_q       <= hdr_len_n;
			hdr_seq_q       <= hdr_seq_n;
			exp_seq_q       <= exp_seq_n;
			fault_q         <= fault_n;
			halted_q        <= halted_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_q.status;
	assign record_type     = out_q.record_type;
	assign record_sequence = out_q.record_sequence;
	assign payload_start   = out_q.payload_start;
	assign payload_length  = out_q.payload_length;
	assign error_offset    = out_q.error_offset;

endmodule

[hdl/jfsc_regs.sv]
// ----------------------------------------------------------------------------
// jfsc_regs
// APB register file: version, payload limit and record type window.
// ----------------------------------------------------------------------------
module jfsc_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [jfsc_pkg::ADDR_BITS-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	output jfsc_pkg::cfg_t                 cfg
);

	jfsc_pkg::cfg_t cfg_q;
	logic [1:0]     idx;
	logic           wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[3:2];
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.schema_version <= jfsc_pkg::SCHEMA_VERSION_RST;
			cfg_q.max_payload    <= jfsc_pkg::MAX_PAYLOAD_RST;
			cfg_q.type_first     <= jfsc_pkg::TYPE_FIRST_RST;
			cfg_q.type_last      <= jfsc_pkg::TYPE_LAST_RST;
		end else if (wr_en) begin
			case (idx)
				jfsc_pkg::REG_SCHEMA_VERSION: cfg_q.schema_version <= pwdata[7:0];
				jfsc_pkg::REG_MAX_PAYLOAD:    cfg_q.max_payload    <= pwdata[23:0];
				jfsc_pkg::REG_TYPE_FIRST:     cfg_q.type_first     <= pwdata[15:0];
				jfsc_pkg::REG_TYPE_LAST:      cfg_q.type_last      <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			jfsc_pkg::REG_SCHEMA_VERSION: prdata = {24'd0, cfg_q.schema_version};
			jfsc_pkg::REG_MAX_PAYLOAD:    prdata = {8'd0, cfg_q.max_payload};
			jfsc_pkg::REG_TYPE_FIRST:     prdata = {16'd0, cfg_q.type_first};
			jfsc_pkg::REG_TYPE_LAST:      prdata = {16'd0, cfg_q.type_last};
			default:                      prdata = 32'd0;
		endcase
	end

endmodule

[hdl/jfsc_checker.sv]
// ----------------------------------------------------------------------------
// jfsc_checker
// Port-level assertions for the journal frame checker, bound to the top level.
// ----------------------------------------------------------------------------
module jfsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  status,
	input logic [15:0] record_type,
	input logic [63:0] record_sequence,
	input logic [31:0] payload_start,
	input logic [23:0] payload_length,
	input logic [31:0] error_offset
);

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(status) && $stable(error_offset) &&
		$stable(record_sequence))
		else $error("result word changed while stalled");

	// record fields only on a good verdict
	a_err_no_record: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != jfsc_pkg::ST_OK |-> record_type == 16'd0 &&
		record_sequence == 64'd0 && payload_start == 32'd0 && payload_length == 24'd0)
		else $error("record fields set on a non-record verdict");

	// no offset with a good verdict or a clean end
	a_ok_no_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == jfsc_pkg::ST_OK || status == jfsc_pkg::ST_CLEAN_END)
		|-> error_offset == 32'd0)
		else $error("error offset set on a non-error verdict");

endmodule

bind journal_frame_stream_checker_unit jfsc_checker u_jfsc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.status          (status),
	.record_type     (record_type),
	.record_sequence (record_sequence),
	.payload_start   (payload_start),
	.payload_length  (payload_length),
	.error_offset    (error_offset)
);
